// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== rtl/sha1_pkg.sv =====
`timescale 1ns / 1ps
package sha1_pkg;

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_BYTE   = 2'd1,
    FUNC_FINISH = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        digest_valid;
    logic [31:0] digest_word0;
    logic [31:0] digest_word1;
    logic [31:0] digest_word2;
    logic [31:0] digest_word3;
    logic [31:0] digest_word4;
  } out_item_t;

  // Classified command from front to back.
  typedef enum logic [1:0] {
    CMD_REJECT = 2'd0,
    CMD_START  = 2'd1,
    CMD_BYTE   = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data_byte;
  } cmd_t;

  localparam int unsigned QueueDepth = 2;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;
  localparam logic [31:0] K0  = 32'h5A827999;
  localparam logic [31:0] K1  = 32'h6ED9EBA1;
  localparam logic [31:0] K2  = 32'h8F1BBCDC;
  localparam logic [31:0] K3  = 32'hCA62C1D6;
  localparam logic [7:0]  PadMark = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } back_state_e;

endpackage

// ===== rtl/sha1_front.sv =====
`timescale 1ns / 1ps
// Accepts items, tracks the open/idle message state and classifies each item.
module sha1_front import sha1_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_item_t in_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output cmd_t     cmd_o,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i
);

  logic open_q, open_d;

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;

  // Classification against message state
  always_comb begin
    open_d          = open_q;
    cmd_o.data_byte = in_i.data_byte;
    cmd_o.cmd       = CMD_REJECT;
    unique case (func_e'(in_i.func))
      FUNC_START:  if (!open_q) begin
        cmd_o.cmd = CMD_START;
        open_d    = 1'b1;
      end
      FUNC_BYTE:   if (open_q) cmd_o.cmd = CMD_BYTE;
      FUNC_FINISH: if (open_q) begin
        cmd_o.cmd = CMD_FINISH;
        open_d    = 1'b0;
      end
      default:     cmd_o.cmd = CMD_REJECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
    end else if (in_valid_i && cmd_ready_i) begin
      open_q <= open_d;
    end
  end

endmodule

// ===== rtl/sha1_queue.sv =====
`timescale 1ns / 1ps
// Small FIFO between front and back.
module sha1_queue import sha1_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t wr_i,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  output cmd_t rd_o,
  output logic rd_valid_o,
  input  logic rd_ready_i
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t          mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic          wr_en, rd_en;

  assign wr_ready_o = (cnt_q != (AW+1)'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;
  assign rd_o       = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wp_q] <= wr_i;
  end

  // Pointers wrap at Depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (rd_en) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

endmodule

// ===== rtl/sha1_back.sv =====
`timescale 1ns / 1ps
// Carries out commands: buffers bytes, runs 80 rounds per block, pads and
// produces results through an output register.
module sha1_back import sha1_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  output out_item_t out_o,
  output logic      out_valid_o,
  input  logic      out_ready_i
);

  back_state_e state_q, state_d;

  logic [31:0] h_q [5];
  logic [31:0] v_q [5];
  logic [31:0] w_q [16];
  logic [5:0]  pos_q;
  logic [63:0] bits_q;
  logic [6:0]  rnd_q;
  logic        fin_q;   // running the final block
  logic        spill_q; // a length block still follows
  out_item_t   out_q;
  logic        out_vld_q;

  logic        take;
  logic        out_free;
  logic [31:0] f, k, t, wt, wnew;
  logic [3:0]  pidx;
  out_item_t   ack_item;

  assign out_free    = !out_vld_q || out_ready_i;
  assign cmd_ready_o = (state_q == ST_IDLE) && out_free;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign out_o       = out_q;
  assign out_valid_o = out_vld_q;

  // Immediate result for start, byte and rejected items
  always_comb begin
    ack_item          = '0;
    ack_item.accepted = (cmd_i.cmd == CMD_START) || (cmd_i.cmd == CMD_BYTE);
  end

  // Round function: schedule word is w_q[0], window shifts each round
  always_comb begin
    wt   = w_q[0];
    wnew = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    wnew = {wnew[30:0], wnew[31]};
    if (rnd_q < 7'd20) begin
      f = (v_q[1] & v_q[2]) ^ (~v_q[1] & v_q[3]);
      k = K0;
    end else if (rnd_q < 7'd40) begin
      f = v_q[1] ^ v_q[2] ^ v_q[3];
      k = K1;
    end else if (rnd_q < 7'd60) begin
      f = (v_q[1] & v_q[2]) ^ (v_q[1] & v_q[3]) ^ (v_q[2] & v_q[3]);
      k = K2;
    end else begin
      f = v_q[1] ^ v_q[2] ^ v_q[3];
      k = K3;
    end
    t = {v_q[0][26:0], v_q[0][31:27]} + f + v_q[4] + k + wt;
  end

  assign pidx = pos_q[5:2];

  // Next-state logic
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take && cmd_i.cmd == CMD_BYTE && pos_q == 6'd63) state_d = ST_ROUND;
        else if (take && cmd_i.cmd == CMD_FINISH) begin
          // marker in the last byte fills the block: compress right away
          state_d = (pos_q == 6'd63) ? ST_ROUND : ST_PAD;
        end
      end
      ST_PAD:   if (pos_q == 6'd63) state_d = ST_ROUND;
      ST_ROUND: if (rnd_q == 7'd79) state_d = ST_ADD;
      ST_ADD: begin
        if (!fin_q) state_d = ST_IDLE;
        else if (spill_q) state_d = ST_PAD;
        else state_d = ST_OUT;
      end
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      bits_q    <= '0;
      rnd_q     <= '0;
      fin_q     <= 1'b0;
      spill_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      // Result valid: set on a new result, cleared once taken
      if ((take && cmd_i.cmd != CMD_FINISH) || (state_q == ST_OUT && out_free)) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: if (take) begin
          rnd_q <= '0;
          unique case (cmd_i.cmd)
            CMD_START: begin
              pos_q  <= '0;
              bits_q <= '0;
            end
            CMD_BYTE: begin
              pos_q  <= pos_q + 6'd1;
              bits_q <= bits_q + 64'd8;
              fin_q  <= 1'b0;
            end
            CMD_FINISH: begin
              fin_q   <= 1'b1;
              spill_q <= (pos_q >= 6'd56);
              pos_q   <= pos_q + 6'd1;
            end
            default: ;
          endcase
        end
        ST_PAD: begin
          pos_q <= pos_q + 6'd1;
          if (pos_q == 6'd63) rnd_q <= '0;
        end
        ST_ROUND: rnd_q <= rnd_q + 7'd1;
        ST_ADD: if (fin_q && spill_q) begin
          pos_q   <= '0;
          spill_q <= 1'b0;
        end
        ST_OUT: if (out_free) pos_q <= '0;
        default: ;
      endcase
    end
  end

  // Datapath: buffer, working words, chaining words, result register
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: if (take) begin
        out_q <= ack_item;
        unique case (cmd_i.cmd)
          CMD_START: begin
            h_q[0] <= IV0; h_q[1] <= IV1; h_q[2] <= IV2;
            h_q[3] <= IV3; h_q[4] <= IV4;
          end
          CMD_BYTE: begin
            w_q[pidx][8*(3-pos_q[1:0]) +: 8] <= cmd_i.data_byte;
            for (int i = 0; i < 5; i++) v_q[i] <= h_q[i];
          end
          CMD_FINISH: begin
            w_q[pidx][8*(3-pos_q[1:0]) +: 8] <= PadMark;
            for (int i = 0; i < 5; i++) v_q[i] <= h_q[i];
          end
          default: ;
        endcase
      end
      ST_PAD: begin
        if (pos_q >= 6'd56 && !spill_q) begin
          if (pos_q[1:0] == 2'd3) begin
            w_q[14] <= bits_q[63:32];
            w_q[15] <= bits_q[31:0];
          end
        end else begin
          w_q[pidx][8*(3-pos_q[1:0]) +: 8] <= 8'h00;
        end
        for (int i = 0; i < 5; i++) v_q[i] <= h_q[i];
      end
      ST_ROUND: begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= wnew;
        v_q[4] <= v_q[3];
        v_q[3] <= v_q[2];
        v_q[2] <= {v_q[1][1:0], v_q[1][31:2]};
        v_q[1] <= v_q[0];
        v_q[0] <= t;
      end
      ST_ADD: for (int i = 0; i < 5; i++) h_q[i] <= h_q[i] + v_q[i];
      ST_OUT: if (out_free) begin
        out_q.accepted     <= 1'b1;
        out_q.digest_valid <= 1'b1;
        out_q.digest_word0 <= h_q[0];
        out_q.digest_word1 <= h_q[1];
        out_q.digest_word2 <= h_q[2];
        out_q.digest_word3 <= h_q[3];
        out_q.digest_word4 <= h_q[4];
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/sha1_message_digest_top.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_ready_o | in_i   (in_item_t)
// out     | output    | out_valid_o/out_ready_i | out_o  (out_item_t)
// A start, a byte that does not fill the block, or a rejected item is
// answered through the queue and the output register. A byte that fills a
// block runs 80 rounds of one shared round unit plus the chaining add. Finish
// pads one byte per cycle and runs one or two blocks.
// Reset clears message state; the buffer and chaining words need none.
// A stalled output holds the back end; the queue takes up to two more items.
module sha1_message_digest_top import sha1_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output out_item_t out_o,
  output logic      out_valid_o,
  input  logic      out_ready_i
);

`include "assert_macros.svh"

  cmd_t fq_cmd, bq_cmd;
  logic fq_valid, fq_ready, bq_valid, bq_ready;

  sha1_front u_front (
    .clk_i, .rst_ni, .in_i, .in_valid_i, .in_ready_o,
    .cmd_o(fq_cmd), .cmd_valid_o(fq_valid), .cmd_ready_i(fq_ready)
  );

  sha1_queue #(.Depth(Depth)) u_queue (
    .clk_i, .rst_ni,
    .wr_i(fq_cmd), .wr_valid_i(fq_valid), .wr_ready_o(fq_ready),
    .rd_o(bq_cmd), .rd_valid_o(bq_valid), .rd_ready_i(bq_ready)
  );

  sha1_back u_back (
    .clk_i, .rst_ni,
    .cmd_i(bq_cmd), .cmd_valid_i(bq_valid), .cmd_ready_o(bq_ready),
    .out_o, .out_valid_o, .out_ready_i
  );

  `ASSERT_IMPL(a_dv_acc, clk_i, rst_ni, !out_valid_o || !out_o.digest_valid || out_o.accepted, "digest without accept")
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result dropped")
  `ASSERT_IMPL(a_rej_zero, clk_i, rst_ni, !out_valid_o || out_o.accepted || out_o.digest_word0 == '0, "rejected item carries data")

endmodule

// ===== tb/sha1_digest_checker.sv =====
`timescale 1ns / 1ps
// Watches both channels, predicts each result of the digest block and
// compares it with what comes out, in order.
module sha1_digest_checker import sha1_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_i,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  out_item_t out_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  output int        fail_count_o,
  output int        pending_o
);

  // Predictor state
  logic [31:0] chain_q [5];
  logic [31:0] blk_q [16];
  logic [5:0]  pos_q;
  logic [63:0] nbits_q;
  logic        open_q;

  out_item_t expected_q [$];

  assign pending_o = expected_q.size();

  function automatic void put_byte(int p, logic [7:0] v);
    blk_q[(p >> 2) & 15][8 * (3 - (p & 3)) +: 8] = v;
  endfunction

  // One 80-round compression of the block buffer into the chaining words
  function automatic void compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    for (int i = 0; i < 16; i++) w[i] = blk_q[i];
    for (int i = 16; i < 80; i++) begin
      x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {x[30:0], x[31]};
    end
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3]; e = chain_q[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) ^ (~b & d); k = K0;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = K1;
      end else if (i < 60) begin
        f = (b & c) ^ (b & d) ^ (c & d); k = K2;
      end else begin
        f = b ^ c ^ d; k = K3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[i];
      e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
    end
    chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d; chain_q[4] += e;
  endfunction

  // Apply one accepted item and return the expected result
  function automatic out_item_t predict_digest(in_item_t it);
    out_item_t r;
    int p;
    r = '0;
    case (func_e'(it.func))
      FUNC_START: begin
        if (!open_q) begin
          chain_q[0] = IV0; chain_q[1] = IV1; chain_q[2] = IV2;
          chain_q[3] = IV3; chain_q[4] = IV4;
          nbits_q = '0; pos_q = '0; open_q = 1'b1;
          r.accepted = 1'b1;
        end
      end
      FUNC_BYTE: begin
        if (open_q) begin
          put_byte(pos_q, it.data_byte);
          nbits_q += 64'd8;
          pos_q += 6'd1;
          if (pos_q == 6'd0) compress_block();
          r.accepted = 1'b1;
        end
      end
      FUNC_FINISH: begin
        if (open_q) begin
          p = pos_q;
          put_byte(p, PadMark);
          p++;
          // marker leaves no room for the length: spill into a second block
          if (p > 56) begin
            while (p < 64) begin put_byte(p, 8'h00); p++; end
            compress_block();
            p = 0;
          end
          while (p < 56) begin put_byte(p, 8'h00); p++; end
          blk_q[14] = nbits_q[63:32];
          blk_q[15] = nbits_q[31:0];
          compress_block();
          pos_q = '0; open_q = 1'b0;
          r.accepted = 1'b1; r.digest_valid = 1'b1;
          r.digest_word0 = chain_q[0]; r.digest_word1 = chain_q[1];
          r.digest_word2 = chain_q[2]; r.digest_word3 = chain_q[3];
          r.digest_word4 = chain_q[4];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      fail_count_o++;
    end
  endfunction

  // Compare outgoing items, then record predictions for incoming ones
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    if (!rst_ni) begin
      pos_q = '0; nbits_q = '0; open_q = 1'b0;
      fail_count_o = 0;
      expected_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result item with no item pending");
          fail_count_o++;
        end else begin
          e = expected_q.pop_front();
          check_field("accepted", e.accepted, out_i.accepted);
          check_field("digest_valid", e.digest_valid, out_i.digest_valid);
          check_field("digest_word0", e.digest_word0, out_i.digest_word0);
          check_field("digest_word1", e.digest_word1, out_i.digest_word1);
          check_field("digest_word2", e.digest_word2, out_i.digest_word2);
          check_field("digest_word3", e.digest_word3, out_i.digest_word3);
          check_field("digest_word4", e.digest_word4, out_i.digest_word4);
        end
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(predict_digest(in_i));
    end
  end

endmodule

// ===== tb/sha1_message_digest_top_tb.sv =====
`timescale 1ns / 1ps
module sha1_message_digest_top_tb import sha1_pkg::*;;

  localparam int IdleLimit = 20000;

  logic      clk;
  logic      rst_n;
  in_item_t  in_item;
  logic      in_valid;
  logic      in_ready;
  out_item_t out_item;
  logic      out_valid;
  logic      out_ready;
  int        fail_count;
  int        pending;
  int        sent_count;
  int        idle_cycles = 0;
  bit        quiet = 1'b0;

  sha1_message_digest_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_item),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .out_o       (out_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready)
  );

  sha1_digest_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_i         (in_item),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .out_i        (out_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Random gap length: mostly short, a few long, none in quiet stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Alternate between stretches with and without idling
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) quiet <= ~quiet;
  end

  // Result side stalls
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // Watchdog on cycles without a transfer on either channel
  always @(posedge clk) begin
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_item(func_e f, logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{func: f, data_byte: b};
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  task automatic send_message(int len);
    send_item(FUNC_START, 8'($urandom_range(0, 255)));
    for (int i = 0; i < len; i++) send_item(FUNC_BYTE, 8'($urandom_range(0, 255)));
    send_item(FUNC_FINISH, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int len;
    int r;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    sent_count  = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: rejects while idle, start while open, unused selector,
    // empty and short messages, extreme byte values
    send_item(FUNC_BYTE, 8'hFF);
    send_item(FUNC_FINISH, 8'h00);
    send_item(FUNC_NONE, 8'hA5);
    send_item(FUNC_START, 8'hFF);
    send_item(FUNC_START, 8'h00);
    send_item(FUNC_NONE, 8'h5A);
    send_item(FUNC_FINISH, 8'hFF);
    send_item(FUNC_START, 8'h00);
    send_item(FUNC_BYTE, 8'h61);
    send_item(FUNC_BYTE, 8'h62);
    send_item(FUNC_BYTE, 8'h63);
    send_item(FUNC_FINISH, 8'h00);
    send_item(FUNC_START, 8'h00);
    send_item(FUNC_BYTE, 8'h00);
    send_item(FUNC_BYTE, 8'hFF);
    send_item(FUNC_FINISH, 8'hFF);

    // Random messages, lengths clustered around the padding boundaries
    while (sent_count < 850) begin
      r = $urandom_range(0, 99);
      if (r < 55) len = $urandom_range(0, 70);
      else if (r < 90) len = $urandom_range(52, 66);
      else len = $urandom_range(100, 200);
      if ($urandom_range(0, 9) == 0) begin
        // broken sequence: noise mixed into a message, maybe left unfinished
        send_item(func_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        send_item(FUNC_START, 8'($urandom_range(0, 255)));
        for (int i = 0; i < len % 20; i++)
          send_item(func_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) send_item(FUNC_FINISH, 8'($urandom_range(0, 255)));
      end else begin
        send_message(len);
      end
    end
    send_item(FUNC_FINISH, 8'($urandom_range(0, 255)));
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
